/* rtl/imubc_pkg.sv */
`default_nettype none

package imubc_pkg;

  localparam int CALIB_SAMPLES = 1000;

  // burst layout: ax ay az temp gx gy gz, big-endian words
  localparam logic [3:0] LAST_POS    = 4'd13;
  localparam logic [3:0] TEMP_HI_POS = 4'd6;
  localparam logic [3:0] TEMP_LO_POS = 4'd7;

  // floor(x / N) estimate: (x * CAL_RECIP) >> 31 is exact or one low for x < 2^31
  localparam logic [31:0] CAL_RECIP = 32'((64'd1 << 31) / CALIB_SAMPLES);
  localparam logic [16:0] CAL_DIV   = 17'(CALIB_SAMPLES);
  localparam logic [15:0] CAL_LAST  = 16'(CALIB_SAMPLES - 1);

  localparam logic [62:0] ACCEL_SCALE_RST = 63'd3290535029813070889;
  localparam logic [62:0] GYRO_SCALE_RST  = 63'd2568305043426521997;

  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_CALIB   = 1'b1;

  typedef enum logic [2:0] {
    REG_FLIP      = 3'd0,
    REG_ACCEL_OFS = 3'd1,
    REG_GYRO_OFS  = 3'd2,
    REG_ACCEL_SCL = 3'd3,
    REG_GYRO_SCL  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        flip;
    logic [47:0] accel_offset;
    logic [47:0] gyro_offset;
    logic [62:0] accel_scale;
    logic [62:0] gyro_scale;
  } cfg_t;

  // word 0..2 accel x/y/z, 3..5 gyro x/y/z, unflipped
  typedef struct packed {
    logic             mode;
    logic [5:0][15:0] word;
  } burst_t;

endpackage

`default_nettype wire

/* rtl/imubc_in_if.sv */
`default_nettype none

interface imubc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] burst_byte;

  modport source(output valid, cmd, burst_byte, input ready);
  modport sink(input valid, cmd, burst_byte, output ready);
endinterface

`default_nettype wire

/* rtl/imubc_out_if.sv */
`default_nettype none

interface imubc_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic signed [31:0] gyro_x;
  logic signed [31:0] gyro_y;
  logic signed [31:0] gyro_z;
  logic [47:0]        raw_accel;
  logic [47:0]        raw_gyro;

  modport source(output valid, result_kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 raw_accel, raw_gyro, input ready);
  modport sink(input valid, result_kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               raw_accel, raw_gyro, output ready);
endinterface

`default_nettype wire

/* rtl/imubc_cfg.sv */
`default_nettype none

module imubc_cfg import imubc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output cfg_t        cfg
);

  logic     wr;
  reg_idx_t idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flip         <= 1'b0;
      cfg.accel_offset <= '0;
      cfg.gyro_offset  <= '0;
      cfg.accel_scale  <= ACCEL_SCALE_RST;
      cfg.gyro_scale   <= GYRO_SCALE_RST;
    end else if (wr) begin
      unique case (idx)
        REG_FLIP:      cfg.flip         <= pwdata[0];
        REG_ACCEL_OFS: cfg.accel_offset <= pwdata[47:0];
        REG_GYRO_OFS:  cfg.gyro_offset  <= pwdata[47:0];
        REG_ACCEL_SCL: cfg.accel_scale  <= pwdata[62:0];
        REG_GYRO_SCL:  cfg.gyro_scale   <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FLIP:      prdata = {63'd0, cfg.flip};
      REG_ACCEL_OFS: prdata = {16'd0, cfg.accel_offset};
      REG_GYRO_OFS:  prdata = {16'd0, cfg.gyro_offset};
      REG_ACCEL_SCL: prdata = {1'b0, cfg.accel_scale};
      REG_GYRO_SCL:  prdata = {1'b0, cfg.gyro_scale};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/imubc_asm.sv */
`default_nettype none

module imubc_asm import imubc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  imubc_in_if.sink    burst,
  output logic        brec_valid,
  input  logic        brec_ready,
  output burst_t      brec
);

  logic [3:0]  pos;
  logic        mode;
  logic [7:0]  hold;
  logic [15:0] word [5];

  logic        acc;
  logic        mode_cur;
  logic [2:0]  widx;

  assign burst.ready = (pos != LAST_POS) || !brec_valid || brec_ready;
  assign acc         = burst.valid && burst.ready;
  assign mode_cur    = (pos == 4'd0) ? burst.cmd : mode;
  // temp word skipped, so gyro words shift down by one slot
  assign widx        = (pos < TEMP_HI_POS) ? pos[3:1] : pos[3:1] - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      mode       <= MODE_MEASURE;
      hold       <= '0;
      brec_valid <= 1'b0;
    end else begin
      if (acc && pos == LAST_POS) begin
        brec_valid <= 1'b1;
      end else if (brec_ready) begin
        brec_valid <= 1'b0;
      end
      if (acc) begin
        mode <= mode_cur;
        if (pos != TEMP_HI_POS && pos != TEMP_LO_POS) begin
          if (!pos[0]) begin
            hold <= burst.burst_byte;
          end else if (pos != LAST_POS) begin
            word[widx] <= {hold, burst.burst_byte};
          end
        end
        if (pos == LAST_POS) begin
          pos        <= '0;
          brec.mode  <= mode_cur;
          brec.word  <= {hold, burst.burst_byte, word[4], word[3], word[2], word[1], word[0]};
        end else begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= LAST_POS)
    else $error("byte position out of range");
  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    acc && pos == LAST_POS |=> brec_valid)
    else $error("burst end did not post a record");
  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    brec_valid && !brec_ready |=> brec_valid && $stable(brec))
    else $error("burst record lost while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/imubc_calc.sv */
`default_nettype none

module imubc_calc import imubc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        brec_valid,
  output logic        brec_ready,
  input  burst_t      brec,
  imubc_out_if.source result
);

  logic adv;

  logic [15:0] calib_count;
  logic [31:0] gyro_sums [3];

  // stage 1: products and calibration magnitudes
  logic               s1_v, s1_kind;
  logic [47:0]        s1_pa, s1_pg;
  logic signed [38:0] s1_prod [6];
  logic [31:0]        s1_mag [3];
  logic               s1_neg [3];
  // stage 2: rounded outputs, quotient estimates
  logic               s2_v, s2_kind;
  logic [47:0]        s2_pa, s2_pg;
  logic signed [31:0] s2_scl [6];
  logic [31:0]        s2_mag [3];
  logic               s2_neg [3];
  logic [15:0]        s2_qe [3];
  // stage 3: remainders
  logic               s3_v, s3_kind;
  logic [47:0]        s3_pa, s3_pg;
  logic signed [31:0] s3_scl [6];
  logic               s3_neg [3];
  logic [15:0]        s3_qe [3];
  logic [16:0]        s3_rem [3];

  logic [15:0]        wf [6];
  logic [15:0]        ofs [6];
  logic [20:0]        scl [6];
  logic signed [16:0] diff [6];
  logic signed [38:0] prod [6];
  logic [31:0]        sum_next [3];
  logic [31:0]        mag [3];
  logic               cal_done;
  logic signed [38:0] rsum [6];
  logic [63:0]        qprod [3];
  logic [31:0]        qd [3];
  logic [15:0]        q [3];
  logic [15:0]        qs [3];
  logic [15:0]        ofs_new [3];

  assign adv        = !result.valid || result.ready;
  assign brec_ready = adv;
  assign cal_done   = (calib_count == CAL_LAST);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      wf[i] = (cfg.flip && (i % 3) != 0) ? ~brec.word[i] : brec.word[i];
      if (i < 3) begin
        ofs[i] = cfg.accel_offset[16*i +: 16];
        scl[i] = cfg.accel_scale[21*i +: 21];
      end else begin
        ofs[i] = cfg.gyro_offset[16*(i-3) +: 16];
        scl[i] = cfg.gyro_scale[21*(i-3) +: 21];
      end
      diff[i] = signed'({wf[i][15], wf[i]}) - signed'({ofs[i][15], ofs[i]});
      prod[i] = diff[i] * signed'({1'b0, scl[i]});
      // round to nearest, ties up, then keep LSB 2^-16
      rsum[i] = s1_prod[i] + 39'sd512;
    end
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = gyro_sums[i] + {{16{brec.word[3+i][15]}}, brec.word[3+i]};
      mag[i]      = sum_next[i][31] ? (32'd0 - sum_next[i]) : sum_next[i];
      qprod[i]    = {32'd0, s1_mag[i]} * {32'd0, CAL_RECIP};
      qd[i]       = {16'd0, s2_qe[i]} * {15'd0, CAL_DIV};
      q[i]        = s3_qe[i] + {15'd0, (s3_rem[i] >= CAL_DIV)};
      qs[i]       = s3_neg[i] ? (16'd0 - q[i]) : q[i];
      ofs_new[i]  = (cfg.flip && i != 0) ? ~qs[i] : qs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      result.valid <= 1'b0;
      calib_count  <= '0;
      for (int i = 0; i < 3; i++) begin
        gyro_sums[i] <= '0;
      end
    end else if (adv) begin
      s1_v    <= brec_valid && (brec.mode == MODE_MEASURE || cal_done);
      s1_kind <= brec.mode;
      s1_pa   <= {wf[2], wf[1], wf[0]};
      s1_pg   <= {wf[5], wf[4], wf[3]};
      for (int i = 0; i < 6; i++) begin
        s1_prod[i] <= prod[i];
      end
      for (int i = 0; i < 3; i++) begin
        s1_mag[i] <= mag[i];
        s1_neg[i] <= sum_next[i][31];
      end
      if (brec_valid && brec.mode == MODE_CALIB) begin
        calib_count <= cal_done ? 16'd0 : calib_count + 16'd1;
        for (int i = 0; i < 3; i++) begin
          gyro_sums[i] <= cal_done ? 32'd0 : sum_next[i];
        end
      end

      s2_v    <= s1_v;
      s2_kind <= s1_kind;
      s2_pa   <= s1_pa;
      s2_pg   <= s1_pg;
      for (int i = 0; i < 6; i++) begin
        s2_scl[i] <= {{3{rsum[i][38]}}, rsum[i][38:10]};
      end
      for (int i = 0; i < 3; i++) begin
        s2_mag[i] <= s1_mag[i];
        s2_neg[i] <= s1_neg[i];
        s2_qe[i]  <= qprod[i][46:31];
      end

      s3_v    <= s2_v;
      s3_kind <= s2_kind;
      s3_pa   <= s2_pa;
      s3_pg   <= s2_pg;
      for (int i = 0; i < 6; i++) begin
        s3_scl[i] <= s2_scl[i];
      end
      for (int i = 0; i < 3; i++) begin
        s3_neg[i] <= s2_neg[i];
        s3_qe[i]  <= s2_qe[i];
        s3_rem[i] <= 17'(s2_mag[i] - qd[i]);
      end

      result.valid       <= s3_v;
      result.result_kind <= s3_kind;
      if (s3_kind == MODE_CALIB) begin
        result.accel_x   <= '0;
        result.accel_y   <= '0;
        result.accel_z   <= '0;
        result.gyro_x    <= '0;
        result.gyro_y    <= '0;
        result.gyro_z    <= '0;
        result.raw_accel <= '0;
        result.raw_gyro  <= {ofs_new[2], ofs_new[1], ofs_new[0]};
      end else begin
        result.accel_x   <= s3_scl[0];
        result.accel_y   <= s3_scl[1];
        result.accel_z   <= s3_scl[2];
        result.gyro_x    <= s3_scl[3];
        result.gyro_y    <= s3_scl[4];
        result.gyro_z    <= s3_scl[5];
        result.raw_accel <= s3_pa;
        result.raw_gyro  <= s3_pg;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) calib_count <= CAL_LAST)
    else $error("calibration count past sample total");
  a_cal_clear: assert property (@(posedge clk) disable iff (rst)
    s1_v && s1_kind == MODE_CALIB |-> calib_count == 16'd0)
    else $error("calibration run not cleared after offsets issued");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    s3_v && s3_kind == MODE_CALIB |->
      s3_rem[0] < 2 * CAL_DIV && s3_rem[1] < 2 * CAL_DIV && s3_rem[2] < 2 * CAL_DIV)
    else $error("quotient estimate off by more than one");
`endif

endmodule

`default_nettype wire

/* rtl/imu_burst_calibrate_scale.sv */
`default_nettype none

// channel   dir  handshake      payload
// burst     in   valid/ready    cmd, burst_byte
// result    out  valid/ready    result_kind, accel_x..z, gyro_x..z, raw_accel, raw_gyro
// apb       in   psel/penable   5 registers at 8-byte spacing, 64-bit data
//
// One byte transaction per cycle while burst.ready is high. After the 14th byte
// of a burst, a result moves through the burst record, multiply, round and divide
// estimate, remainder and output registers.
// Synchronous reset clears byte position, calibration count, sums and all valids.
// A stalled result freezes the pipeline; burst bytes still flow except the last
// byte of a burst, which waits until the burst record can move on.

module imu_burst_calibrate_scale import imubc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  imubc_in_if.sink    burst,
  imubc_out_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  logic   brec_valid;
  logic   brec_ready;
  burst_t brec;

  assign pready = 1'b1;

  imubc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  imubc_asm u_asm (
    .clk        (clk),
    .rst        (rst),
    .burst      (burst),
    .brec_valid (brec_valid),
    .brec_ready (brec_ready),
    .brec       (brec)
  );

  imubc_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .brec_valid (brec_valid),
    .brec_ready (brec_ready),
    .brec       (brec),
    .result     (result)
  );

endmodule

`default_nettype wire
